>>> hdl/mpool_pkg.sv
// Shared types and constants for the 2x2 stride-2 max pooling stream block.
package mpool_pkg;

    localparam int DATA_W      = 16;
    localparam int MAX_WIDTH   = 256;
    localparam int POOL_STRIDE = 2;
    localparam int STORE_DEPTH = MAX_WIDTH / POOL_STRIDE;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 9;
    localparam int CHAN_W      = 10;
    localparam int CHCNT_W     = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_VALUE   = 2'd2;

    localparam logic [CHCNT_W-1:0] CHANNELS_RESET = 11'd16;
    localparam logic [CHCNT_W-1:0] CHANNELS_MAX   = 11'd1024;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET    = 9'd256;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN      = 9'd2;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX      = 9'(MAX_WIDTH);
    localparam logic signed [DATA_W-1:0] FLOOR_RESET = -16'sd10000;

    typedef logic signed [DATA_W-1:0] t_data;

    // Work handed from front to back: a pair maximum to store, or to pool.
    typedef struct packed {
        logic              emit;
        logic [SLOT_W-1:0] slot;
        t_data             pair_max;
        logic              last;
    } t_cmd;

endpackage

>>> hdl/mpool_in_if.sv
// Sample input channel.
interface mpool_in_if import mpool_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/mpool_out_if.sv
// Pooled result output channel.
interface mpool_out_if import mpool_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data pooled_value;
    logic  run_last;

    modport source (output valid, output pooled_value, output run_last, input ready);
    modport sink   (input valid, input pooled_value, input run_last, output ready);
endinterface

>>> hdl/mpool_cfg_if.sv
// Configuration write channel.
interface mpool_cfg_if import mpool_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/mpool_front.sv
// Front end: raster position counters and pair maximum, issues store/pool commands.
module mpool_front import mpool_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_data                i_sample,
    input  logic [CHCNT_W-1:0]   i_channel_count,
    input  logic [WIDTH_W-1:0]   i_row_width,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    input  logic                 i_full
);
    logic [COL_W-1:0]   r_col, n_col;
    logic [COL_W-1:0]   r_row, n_row;
    logic [CHAN_W-1:0]  r_chan, n_chan;
    t_data              r_first;
    logic [WIDTH_W-1:0] w_even, w_eff;
    logic [CHCNT_W-1:0] c_eff;
    logic               accept, last_col, last_row, last_ch;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        w_even = i_row_width & ~WIDTH_W'(1);
        if (w_even < WIDTH_MIN) begin
            w_eff = WIDTH_MIN;
        end else if (w_even > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = w_even;
        end
        if (i_channel_count == '0) begin
            c_eff = CHCNT_W'(1);
        end else if (i_channel_count > CHANNELS_MAX) begin
            c_eff = CHANNELS_MAX;
        end else begin
            c_eff = i_channel_count;
        end
    end

    // Counters past a lowered bound wrap as if they had reached it.
    assign last_col = (WIDTH_W'(r_col) + WIDTH_W'(1)) >= w_eff;
    assign last_row = (WIDTH_W'(r_row) + WIDTH_W'(1)) >= w_eff;
    assign last_ch  = (CHCNT_W'(r_chan) + CHCNT_W'(1)) >= c_eff;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_chan = r_chan;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row  = '0;
                    n_chan = last_ch ? '0 : r_chan + CHAN_W'(1);
                end else begin
                    n_row = r_row + COL_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_chan <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_chan <= n_chan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_col[0]) begin
            r_first <= i_sample;
        end
    end

    assign o_push         = accept && r_col[0];
    assign o_cmd.emit     = r_row[0];
    assign o_cmd.slot     = r_col[COL_W-1:1];
    assign o_cmd.pair_max = (i_sample > r_first) ? i_sample : r_first;
    assign o_cmd.last     = last_col && last_row && last_ch;

endmodule

>>> hdl/mpool_queue.sv
// Short command queue between front and back.
module mpool_queue import mpool_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);
    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_pop;

    assign o_full  = r_cnt == Q_CNT_W'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> hdl/mpool_back.sv
// Back end: line store of pair maxima, window maximum, floor and output register.
module mpool_back import mpool_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_cmd  i_cmd,
    output logic  o_pop,
    input  t_data i_floor,
    output logic  o_valid,
    input  logic  i_ready,
    output t_data o_pooled_value,
    output logic  o_run_last
);
    t_data r_store [STORE_DEPTH];
    logic  r_a_valid;
    t_data r_a_pair;
    t_data r_a_stored;
    logic  r_a_last;
    logic  r_o_valid;
    t_data r_o_value;
    logic  r_o_last;
    logic  out_free, a_move, a_free, pop;
    t_data win_max, pooled;

    assign out_free = !r_o_valid || i_ready;
    assign a_move   = r_a_valid && out_free;
    assign a_free   = !r_a_valid || out_free;
    assign pop      = i_q_valid && a_free;
    assign o_pop    = pop;

    // Store writes and pool reads of a slot come from different rows,
    // so a read never meets a write of the same slot in one cycle.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_cmd.emit) begin
                r_a_stored <= r_store[i_cmd.slot];
                r_a_pair   <= i_cmd.pair_max;
                r_a_last   <= i_cmd.last;
            end else begin
                r_store[i_cmd.slot] <= i_cmd.pair_max;
            end
        end
    end

    assign win_max = (r_a_pair > r_a_stored) ? r_a_pair : r_a_stored;
    assign pooled  = (win_max > i_floor) ? win_max : i_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop && i_cmd.emit) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_o_value <= pooled;
            r_o_last  <= r_a_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_pooled_value = r_o_value;
    assign o_run_last     = r_o_last;

endmodule

>>> hdl/maxpool_2x2_stream.sv
// Top level of the 2x2 stride-2 max pooling stream block.
// Takes one signed sample per clock as a raster stream of square images
// (row_width x row_width, row_width even, up to 256), one image per channel,
// channel_count channels per run. Each sample is a one-cycle transaction;
// results leave one per clock at most. A window closed by a sample passes
// a four-entry command queue, a line-store read stage and an output
// register, and is held while the output is stalled. The result
// is the window maximum, not below floor_value; run_last marks the final
// result of the run. Output stalls back up through the queue and only then
// stop input. Configuration writes take effect at once and are meant for
// idle periods; the line store holds no reset content.
module maxpool_2x2_stream import mpool_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mpool_in_if.sink    i_sample_ch,
    mpool_out_if.source o_pool_ch,
    mpool_cfg_if.sink   i_cfg
);
    logic [CHCNT_W-1:0] r_channel_count;
    logic [WIDTH_W-1:0] r_row_width;
    t_data              r_floor;
    logic               push, full, q_valid, pop;
    t_cmd               push_cmd, q_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHANNELS_RESET;
            r_row_width     <= WIDTH_RESET;
            r_floor         <= FLOOR_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg.data[CHCNT_W-1:0];
                CFG_ROW_WIDTH:     r_row_width     <= i_cfg.data[WIDTH_W-1:0];
                CFG_FLOOR_VALUE:   r_floor         <= t_data'(i_cfg.data);
                default: ;
            endcase
        end
    end

    mpool_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_sample_ch.valid),
        .o_ready         (i_sample_ch.ready),
        .i_sample        (i_sample_ch.sample),
        .i_channel_count (r_channel_count),
        .i_row_width     (r_row_width),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .i_full          (full)
    );

    mpool_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    mpool_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (pop),
        .i_floor        (r_floor),
        .o_valid        (o_pool_ch.valid),
        .i_ready        (o_pool_ch.ready),
        .o_pooled_value (o_pool_ch.pooled_value),
        .o_run_last     (o_pool_ch.run_last)
    );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the 2x2 stride-2 max pooling stream block.
`timescale 1ns / 1ps

module testbench;
    import mpool_pkg::*;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 8;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          MAX_REPORTS  = 30;
    localparam int unsigned SAMPLE_GOAL  = 2000;

    // First image: extremes and ties, floor crossings, values near the reset floor.
    localparam t_data CORNER_IMG [16] = '{
        -32768, -32768,  32767,     -1,
        -32768, -20000,      5,  32766,
            -1,     -2,      0,      1,
            -3,     -4,  -9999, -10001
    };

    typedef enum int {
        READY_STEADY,
        READY_COIN,
        READY_MOSTLY,
        READY_STALL
    } t_ready_mode;

    typedef struct packed {
        t_data value;
        logic  last;
    } t_window_result;

    // Tracks the raster position and line store, predicts each pooled window.
    class t_window_max_tracker;
        logic [CHCNT_W-1:0] chan_reg;
        logic [WIDTH_W-1:0] width_reg;
        t_data              floor_reg;
        t_data              pair_max_store [STORE_DEPTH];
        bit                 slot_written [STORE_DEPTH];
        t_data              pair_first;
        int unsigned        col_pos;
        int unsigned        row_pos;
        int unsigned        chan_pos;
        t_window_result     pending_windows [$];
        int unsigned        errors;
        int unsigned        samples_seen;
        int unsigned        windows_checked;
        int unsigned        runs_closed;
        int unsigned        reg_writes;

        function new();
            chan_reg        = CHANNELS_RESET;
            width_reg       = WIDTH_RESET;
            floor_reg       = FLOOR_RESET;
            pair_first      = '0;
            col_pos         = 0;
            row_pos         = 0;
            chan_pos        = 0;
            errors          = 0;
            samples_seen    = 0;
            windows_checked = 0;
            runs_closed     = 0;
            reg_writes      = 0;
            foreach (slot_written[k]) slot_written[k] = 1'b0;
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg & ~9'd1;
            if (w < WIDTH_MIN) w = WIDTH_MIN;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int unsigned eff_channels();
            int unsigned c;
            c = chan_reg;
            if (c < 1) c = 1;
            if (c > CHANNELS_MAX) c = CHANNELS_MAX;
            return c;
        endfunction

        function t_data larger(t_data a, t_data b);
            return (a > b) ? a : b;
        endfunction

        // Counters at or past a bound wrap as if they had just reached it.
        function void advance(inout int unsigned c, inout int unsigned r,
                              inout int unsigned ch);
            int unsigned w;
            int unsigned n;
            w = eff_width();
            n = eff_channels();
            if (c + 1 >= w) begin
                c = 0;
                if (r + 1 >= w) begin
                    r  = 0;
                    ch = (ch + 1 >= n) ? 0 : ch + 1;
                end else begin
                    r = r + 1;
                end
            end else begin
                c = c + 1;
            end
        endfunction

        // Samples needed to bring the position back to the start of a run.
        function int unsigned samples_to_wrap();
            int unsigned c;
            int unsigned r;
            int unsigned ch;
            int unsigned n;
            c  = col_pos;
            r  = row_pos;
            ch = chan_pos;
            n  = 0;
            do begin
                advance(c, r, ch);
                n++;
            end while (c != 0 || r != 0 || ch != 0);
            return n;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            reg_writes++;
            case (idx)
                CFG_CHANNEL_COUNT: chan_reg  = value[CHCNT_W-1:0];
                CFG_ROW_WIDTH:     width_reg = value[WIDTH_W-1:0];
                CFG_FLOOR_VALUE:   floor_reg = t_data'(value);
                default: ;
            endcase
        endfunction

        function void note_sample(t_data s);
            int unsigned    slot;
            bit             run_end;
            t_data          m;
            t_window_result r;
            samples_seen++;
            slot    = (col_pos / POOL_STRIDE) % STORE_DEPTH;
            run_end = (col_pos + 1 >= eff_width()) && (row_pos + 1 >= eff_width())
                   && (chan_pos + 1 >= eff_channels());
            if (col_pos % 2 == 0) begin
                pair_first = s;
            end else if (row_pos % 2 == 0) begin
                pair_max_store[slot] = larger(pair_first, s);
                slot_written[slot]   = 1'b1;
            end else begin
                if (!slot_written[slot]) begin
                    errors++;
                    $display("%0t: stimulus read line store slot %0d before any write",
                             $time, slot);
                end
                m       = larger(larger(pair_first, s), pair_max_store[slot]);
                r.value = larger(m, floor_reg);
                r.last  = run_end;
                pending_windows.push_back(r);
            end
            advance(col_pos, row_pos, chan_pos);
        endfunction

        function void check_pooled(t_data got_value, logic got_last);
            t_window_result exp_r;
            if (pending_windows.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected pooled result, expected none, got %0d last %b",
                             $time, got_value, got_last);
                return;
            end
            exp_r = pending_windows.pop_front();
            windows_checked++;
            if (exp_r.last) runs_closed++;
            if (got_value !== exp_r.value) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: pooled_value mismatch, expected %0d, got %0d",
                             $time, exp_r.value, got_value);
            end
            if (got_last !== exp_r.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: run_last mismatch, expected %b, got %b",
                             $time, exp_r.last, got_last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mpool_in_if  sample_bus ();
    mpool_out_if pool_bus ();
    mpool_cfg_if cfg_bus ();

    t_window_max_tracker tracker;

    t_ready_mode ready_mode;
    int unsigned ready_left;

    maxpool_2x2_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_bus),
        .o_pool_ch   (pool_bus),
        .i_cfg       (cfg_bus)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Receiver back-pressure: spans of steady, random, mostly-ready or stalled.
    initial ready_left = 0;
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_left = (ready_mode == READY_STALL) ? $urandom_range(1, 20)
                                                     : $urandom_range(8, 80);
        end
        ready_left = ready_left - 1;
        case (ready_mode)
            READY_STEADY: pool_bus.ready <= 1'b1;
            READY_COIN:   pool_bus.ready <= 1'($urandom_range(0, 1));
            READY_MOSTLY: pool_bus.ready <= ($urandom_range(0, 7) != 0);
            default:      pool_bus.ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready)
                tracker.write_reg(cfg_bus.index, cfg_bus.data);
            if (sample_bus.valid && sample_bus.ready)
                tracker.note_sample(sample_bus.sample);
            if (pool_bus.valid && pool_bus.ready)
                tracker.check_pooled(pool_bus.pooled_value, pool_bus.run_last);
        end
    end

    function automatic t_data pick_sample();
        case ($urandom_range(0, 9))
            0:       return t_data'(16'h8000);
            1:       return t_data'(16'h7FFF);
            2:       return t_data'(int'($urandom_range(0, 64)) - 32);
            3:       return tracker.floor_reg + t_data'(int'($urandom_range(0, 4)) - 2);
            default: return t_data'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_floor();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // The wait after the transaction keeps back-to-back writes apart and
    // lets the tracker see the new value before the caller looks at it.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_sample(t_data s);
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= s;
        @(posedge i_clk);
        while (!sample_bus.ready) @(posedge i_clk);
    endtask

    task automatic feed_random(int unsigned n);
        int unsigned burst;
        int unsigned gap;
        burst = 0;
        for (int unsigned k = 0; k < n; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    sample_bus.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst--;
            push_sample(pick_sample());
        end
        sample_bus.valid <= 1'b0;
    endtask

    // Waits first so the monitor has logged the last accepted sample.
    task automatic wait_idle();
        @(posedge i_clk);
        while (tracker.pending_windows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic finish_run();
        feed_random(tracker.samples_to_wrap());
        wait_idle();
    endtask

    initial begin
        int unsigned run_len;
        tracker           = new();
        i_rst_n           = 1'b0;
        sample_bus.valid  = 1'b0;
        sample_bus.sample = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = CFG_CHANNEL_COUNT;
        cfg_bus.data      = '0;
        pool_bus.ready    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one 4x4 image at the reset floor, then both floor extremes.
        write_cfg(CFG_CHANNEL_COUNT, 16'd1);
        write_cfg(CFG_ROW_WIDTH, 16'd4);
        foreach (CORNER_IMG[k]) push_sample(CORNER_IMG[k]);
        sample_bus.valid <= 1'b0;
        wait_idle();
        write_cfg(CFG_ROW_WIDTH, 16'd2);
        write_cfg(CFG_FLOOR_VALUE, 16'h7FFF);
        repeat (4) push_sample(t_data'(16'h8000));
        sample_bus.valid <= 1'b0;
        wait_idle();
        write_cfg(CFG_FLOOR_VALUE, 16'h8000);
        repeat (4) push_sample(t_data'(16'h8000));
        sample_bus.valid <= 1'b0;
        wait_idle();

        // Full width: the first row fills every line store slot, then shrink mid-image.
        write_cfg(CFG_ROW_WIDTH, 16'd256);
        write_cfg(CFG_CHANNEL_COUNT, 16'd2);
        feed_random(2 * 256 + 40);
        wait_idle();
        write_cfg(CFG_ROW_WIDTH, 16'd4);
        write_cfg(CFG_FLOOR_VALUE, pick_floor());
        finish_run();

        // All-ones writes: width clamps to the maximum, count to 1024.
        write_cfg(CFG_ROW_WIDTH, 16'hFFFF);
        write_cfg(CFG_CHANNEL_COUNT, 16'hFFFF);
        feed_random(2 * 256 + 8);
        wait_idle();
        write_cfg(CFG_CHANNEL_COUNT, 16'd1);
        write_cfg(CFG_ROW_WIDTH, 16'd2);
        finish_run();

        // Deep channel count, cut short by a count of zero (treated as one).
        write_cfg(CFG_CHANNEL_COUNT, 16'd1024);
        feed_random(300);
        wait_idle();
        write_cfg(CFG_CHANNEL_COUNT, 16'd0);
        finish_run();

        while (tracker.samples_seen < SAMPLE_GOAL) begin
            if ($urandom_range(0, 3) != 0)
                write_cfg(CFG_ROW_WIDTH, ($urandom_range(0, 7) == 0) ? 16'($urandom_range(11, 24))
                                                                    : 16'($urandom_range(0, 10)));
            if ($urandom_range(0, 3) != 0)
                write_cfg(CFG_CHANNEL_COUNT, 16'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0)
                write_cfg(CFG_FLOOR_VALUE, pick_floor());
            run_len = tracker.samples_to_wrap();
            if (run_len > 1 && $urandom_range(0, 3) == 0) begin
                feed_random($urandom_range(1, run_len - 1));
                wait_idle();
                case ($urandom_range(0, 2))
                    0:       write_cfg(CFG_ROW_WIDTH, 16'($urandom_range(0, 16)));
                    1:       write_cfg(CFG_CHANNEL_COUNT, 16'($urandom_range(0, 4)));
                    default: write_cfg(CFG_FLOOR_VALUE, pick_floor());
                endcase
            end
            finish_run();
        end

        wait_idle();
        $display("Run covered %0d samples, %0d pooled windows, %0d register writes,",
                 tracker.samples_seen, tracker.windows_checked, tracker.reg_writes);
        $display("and %0d completed runs flagged on their last window.", tracker.runs_closed);
        if (tracker.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out waiting for the stream to finish.");
        $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> files.f
hdl/mpool_pkg.sv
hdl/mpool_in_if.sv
hdl/mpool_out_if.sv
hdl/mpool_cfg_if.sv
hdl/mpool_front.sv
hdl/mpool_queue.sv
hdl/mpool_back.sv
hdl/maxpool_2x2_stream.sv
dv/testbench.sv
